// ===== sv/dlc_pkg.sv =====
// Shared types, constants and constant tables for the domain label classifier.
package dlc_pkg;

  localparam int MAX_LABEL   = 63;
  localparam int SYMBOL_BINS = 256;
  localparam int LEN_SAT     = MAX_LABEL + 1;

  localparam int BIN_W   = $clog2(SYMBOL_BINS);
  localparam int CNT_W   = $clog2(MAX_LABEL + 1);
  localparam int LEN_W   = $clog2(MAX_LABEL + 2);
  localparam int SUM_W   = $clog2(MAX_LABEL * CNT_W * 65536 + 1);
  localparam int DELTA_W = 16 + $clog2(CNT_W + 2);

  localparam int LONG_LIMIT_W   = 6;
  localparam int ENT_LIMIT_W    = 20;
  localparam int DIGIT_RATIO_W  = 4;
  localparam int MIN_LENGTH_W   = 6;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 20;
  localparam int LABEL_W        = 7;
  localparam int LABEL_SAT      = 64;

  localparam int LGATE_W = (LEN_W > MIN_LENGTH_W) ? LEN_W : MIN_LENGTH_W;
  localparam int LSAT_W  = (LEN_W > LABEL_W) ? LEN_W : LABEL_W;
  localparam int DIG_W   = CNT_W + 4;
  localparam int LIM_W   = ENT_LIMIT_W + CNT_W;
  localparam int ENT_W   = (SUM_W > LIM_W) ? SUM_W : LIM_W;

  localparam int DIGIT_SCALE = 10;

  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] BIN_MAX      = 8'hFF;

  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_LONG     = 3'd1,
    REASON_ENTROPY  = 3'd2,
    REASON_DIGITS   = 3'd3,
    REASON_NO_VOWEL = 3'd4
  } reason_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LONG_LIMIT    = 3'd0,
    CFG_ENTROPY_LIMIT = 3'd1,
    CFG_DIGIT_RATIO   = 3'd2,
    CFG_DIGIT_MIN     = 3'd3,
    CFG_VOWEL_MIN     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LONG_LIMIT_W-1:0]  long_limit;
    logic [ENT_LIMIT_W-1:0]   entropy_limit;
    logic [DIGIT_RATIO_W-1:0] digit_ratio;
    logic [MIN_LENGTH_W-1:0]  digit_min;
    logic [MIN_LENGTH_W-1:0]  vowel_min;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] digits;
    logic             vowel;
  } snap_t;

  typedef logic [SUM_W-1:0]   nlogn_tab_t [2**CNT_W];
  typedef logic [DELTA_W-1:0] delta_tab_t [2**CNT_W];

  // log2 in unsigned Q16, fraction found by repeated squaring of a Q30 mantissa.
  function automatic logic [31:0] log2_q16(int unsigned x);
    int unsigned k;
    logic [63:0] y;
    logic [15:0] frac;
    k = 0;
    frac = '0;
    if (x == 0) begin
      return 32'd0;
    end
    for (int i = 1; i < 32; i++) begin
      if ((x >> i) != 0) begin
        k = i;
      end
    end
    y = 64'(x) << (30 - k);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd2 << 30)) begin
        frac[0] = 1'b1;
        y = y >> 1;
      end
    end
    return {k[15:0], frac};
  endfunction

  function automatic nlogn_tab_t build_nlogn();
    nlogn_tab_t t;
    for (int i = 0; i < 2**CNT_W; i++) begin
      t[i] = SUM_W'(64'(i) * 64'(log2_q16(i)));
    end
    return t;
  endfunction

  function automatic delta_tab_t build_delta();
    delta_tab_t t;
    for (int i = 0; i < 2**CNT_W; i++) begin
      t[i] = DELTA_W'(64'(i + 1) * 64'(log2_q16(i + 1)) - 64'(i) * 64'(log2_q16(i)));
    end
    return t;
  endfunction

  // Count times log2 of count, indexed by label length.
  localparam nlogn_tab_t NLOGN = build_nlogn();
  // Growth of f*log2(f) when a bin goes from f to f+1, indexed by f.
  localparam delta_tab_t FLOGF_DELTA = build_delta();

endpackage

// ===== sv/dlc_cfg_regs.sv =====
// Configuration register file for the domain label classifier.
module dlc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dlc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dlc_pkg::cfg_t                  cfg
);
  import dlc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_limit    <= LONG_LIMIT_W'(20);
      cfg.entropy_limit <= ENT_LIMIT_W'(249037);
      cfg.digit_ratio   <= DIGIT_RATIO_W'(3);
      cfg.digit_min     <= MIN_LENGTH_W'(5);
      cfg.vowel_min     <= MIN_LENGTH_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LONG_LIMIT:    cfg.long_limit    <= cfg_data[LONG_LIMIT_W-1:0];
        CFG_ENTROPY_LIMIT: cfg.entropy_limit <= cfg_data[ENT_LIMIT_W-1:0];
        CFG_DIGIT_RATIO:   cfg.digit_ratio   <= cfg_data[DIGIT_RATIO_W-1:0];
        CFG_DIGIT_MIN:     cfg.digit_min     <= cfg_data[MIN_LENGTH_W-1:0];
        CFG_VOWEL_MIN:     cfg.vowel_min     <= cfg_data[MIN_LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/dlc_hist.sv =====
// Character intake, label histogram and running f*log2(f) sum.
module dlc_hist (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [15:0]    char_code,
  input  logic           has_char,
  input  logic           last,
  output logic           snap_valid,
  output dlc_pkg::snap_t snap,
  input  logic           snap_ready
);
  import dlc_pkg::*;

  logic [CNT_W-1:0] hist_mem [SYMBOL_BINS];
  logic [CNT_W-1:0] rdata;
  logic [SYMBOL_BINS-1:0] bin_valid;

  logic             a_vld;
  logic [BIN_W-1:0] a_bin;
  logic             a_has;
  logic             a_last;
  logic             a_dot;
  logic             a_digit;
  logic             a_vowel;

  logic             fwd_vld;
  logic [BIN_W-1:0] fwd_bin;
  logic [CNT_W-1:0] fwd_val;

  logic             dot_seen;
  logic [LEN_W-1:0] length;
  logic [CNT_W-1:0] digits;
  logic             vowel_found;
  logic [SUM_W-1:0] flogf_sum;

  logic             dot_seen_next;
  logic [LEN_W-1:0] length_next;
  logic [CNT_W-1:0] digits_next;
  logic             vowel_found_next;
  logic [SUM_W-1:0] flogf_sum_next;

  logic             front_en;
  logic [7:0]       raw_bin;
  logic [BIN_W-1:0] in_bin;
  logic             take;
  logic             at_cap;
  logic             count_en;
  logic [CNT_W-1:0] old_count;
  logic [CNT_W-1:0] new_count;

  always_comb begin
    if (char_code > 16'(BIN_MAX)) begin
      raw_bin = CHAR_X;
    end else begin
      raw_bin = char_code[7:0];
    end
    if (raw_bin inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      in_bin = BIN_W'(raw_bin + CASE_OFFSET);
    end else begin
      in_bin = BIN_W'(raw_bin);
    end
  end

  assign front_en   = !(a_vld && a_last) || snap_ready;
  assign in_stall   = !front_en;
  assign snap_valid = a_vld && a_last;

  always_comb begin
    take      = a_vld && a_has && !dot_seen && !a_dot;
    at_cap    = length >= LEN_W'(MAX_LABEL);
    count_en  = take && !at_cap;
    if (fwd_vld && (fwd_bin == a_bin)) begin
      old_count = fwd_val;
    end else if (bin_valid[a_bin]) begin
      old_count = rdata;
    end else begin
      old_count = '0;
    end
    new_count = old_count + CNT_W'(1);

    dot_seen_next    = dot_seen || (a_vld && a_has && a_dot);
    length_next      = (take && (length < LEN_W'(LEN_SAT))) ? length + LEN_W'(1) : length;
    digits_next      = digits + CNT_W'(count_en && a_digit);
    vowel_found_next = vowel_found || (count_en && a_vowel);
    flogf_sum_next   = count_en ? flogf_sum + SUM_W'(FLOGF_DELTA[old_count]) : flogf_sum;

    snap.length = length_next;
    snap.n      = (length_next >= LEN_W'(MAX_LABEL)) ? CNT_W'(MAX_LABEL)
                                                      : length_next[CNT_W-1:0];
    snap.sum    = flogf_sum_next;
    snap.digits = digits_next;
    snap.vowel  = vowel_found_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld       <= 1'b0;
      fwd_vld     <= 1'b0;
      dot_seen    <= 1'b0;
      length      <= '0;
      digits      <= '0;
      vowel_found <= 1'b0;
      flogf_sum   <= '0;
      bin_valid   <= '0;
    end else if (front_en) begin
      a_vld   <= in_valid;
      fwd_vld <= count_en && !a_last;
      if (a_vld && a_last) begin
        dot_seen    <= 1'b0;
        length      <= '0;
        digits      <= '0;
        vowel_found <= 1'b0;
        flogf_sum   <= '0;
        bin_valid   <= '0;
      end else begin
        dot_seen    <= dot_seen_next;
        length      <= length_next;
        digits      <= digits_next;
        vowel_found <= vowel_found_next;
        flogf_sum   <= flogf_sum_next;
        if (count_en) begin
          bin_valid[a_bin] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      a_bin   <= in_bin;
      a_has   <= has_char;
      a_last  <= last;
      a_dot   <= char_code == 16'(CHAR_DOT);
      a_digit <= char_code inside {[16'(CHAR_ZERO):16'(CHAR_NINE)]};
      a_vowel <= char_code inside {16'h61, 16'h65, 16'h69, 16'h6F, 16'h75,
                                   16'h41, 16'h45, 16'h49, 16'h4F, 16'h55};
      fwd_bin <= a_bin;
      fwd_val <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      rdata <= hist_mem[in_bin];
      if (count_en) begin
        hist_mem[a_bin] <= new_count;
      end
    end
  end

endmodule

// ===== sv/dlc_eval.sv =====
// Label tests, reason priority and the result register.
module dlc_eval (
  input  logic                         clk,
  input  logic                         rst,
  input  dlc_pkg::cfg_t                cfg,
  input  logic                         snap_valid,
  input  dlc_pkg::snap_t               snap,
  output logic                         snap_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         suspicious,
  output logic [2:0]                   reason,
  output logic [dlc_pkg::LABEL_W-1:0]  label_length
);
  import dlc_pkg::*;

  logic  s_vld;
  snap_t s;

  logic               e_vld;
  logic               e_long;
  logic               e_digit;
  logic               e_vowel;
  logic [SUM_W-1:0]   e_hn;
  logic [LIM_W-1:0]   e_lim;
  logic [LABEL_W-1:0] e_len;

  logic               out_en;
  logic               e_en;
  logic               long_hit;
  logic               digit_hit;
  logic               vowel_hit;
  logic [SUM_W-1:0]   hn;
  logic [LIM_W-1:0]   lim;
  logic [DIG_W-1:0]   dig_lhs;
  logic [DIG_W-1:0]   dig_rhs;
  logic [LSAT_W-1:0]  len_ext;
  logic [LABEL_W-1:0] len_sat;
  logic               ent_hit;
  reason_t            reason_next;
  reason_t            out_reason;

  assign out_en     = !out_valid || !out_stall;
  assign e_en       = !e_vld || out_en;
  assign snap_ready = !s_vld || e_en;

  always_comb begin
    long_hit  = LGATE_W'(s.length) > LGATE_W'(cfg.long_limit);
    dig_lhs   = DIG_W'(s.digits) * DIG_W'(DIGIT_SCALE);
    dig_rhs   = DIG_W'(s.n) * DIG_W'(cfg.digit_ratio);
    digit_hit = (LGATE_W'(s.length) > LGATE_W'(cfg.digit_min)) && (dig_lhs > dig_rhs);
    vowel_hit = (LGATE_W'(s.length) > LGATE_W'(cfg.vowel_min)) && !s.vowel;
    hn        = NLOGN[s.n] - s.sum;
    lim       = LIM_W'(cfg.entropy_limit) * LIM_W'(s.n);
    len_ext   = LSAT_W'(s.length);
    len_sat   = (len_ext > LSAT_W'(LABEL_SAT)) ? LABEL_W'(LABEL_SAT) : LABEL_W'(len_ext);
  end

  always_comb begin
    ent_hit = ENT_W'(e_hn) > ENT_W'(e_lim);
    if (e_long) begin
      reason_next = REASON_LONG;
    end else if (ent_hit) begin
      reason_next = REASON_ENTROPY;
    end else if (e_digit) begin
      reason_next = REASON_DIGITS;
    end else if (e_vowel) begin
      reason_next = REASON_NO_VOWEL;
    end else begin
      reason_next = REASON_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld     <= 1'b0;
      e_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (snap_ready) begin
        s_vld <= snap_valid;
      end
      if (e_en) begin
        e_vld <= s_vld;
      end
      if (out_en) begin
        out_valid <= e_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready) begin
      s <= snap;
    end
    if (e_en) begin
      e_long  <= long_hit;
      e_digit <= digit_hit;
      e_vowel <= vowel_hit;
      e_hn    <= hn;
      e_lim   <= lim;
      e_len   <= len_sat;
    end
    if (out_en) begin
      out_reason   <= reason_next;
      suspicious   <= reason_next != REASON_NONE;
      label_length <= e_len;
    end
  end

  assign reason = out_reason;

endmodule

// ===== sv/dga_domain_label_classifier_core.sv =====
// Top level of the domain label classifier.
//
//   Channel   Signals                                   Direction  Handshake
//   input     char_code, has_char, last                 in         in_valid / in_stall
//   result    suspicious, reason, label_length          out        out_valid / out_stall
//   config    cfg_index, cfg_data                       in         cfg_valid / cfg_ready
//
// One character is accepted every cycle while in_stall is low; the histogram read-modify-write on the
// bin memory is the recurrence, with the previous cycle's write forwarded.
// After its last item is accepted, a result passes the snapshot, test evaluation and
// result registers behind the intake register before it is valid.
// Reset clears the per-domain state and all bin valid bits at once; no sweep.
// Input stalls only when a last item is held, the whole result path is full and the result is stalled.
module dga_domain_label_classifier_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     char_code,
  input  logic                            has_char,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            suspicious,
  output logic [2:0]                      reason,
  output logic [dlc_pkg::LABEL_W-1:0]     label_length,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dlc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dlc_pkg::*;

  cfg_t  cfg;
  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  dlc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dlc_hist u_hist (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .has_char   (has_char),
    .last       (last),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  dlc_eval u_eval (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .snap_valid   (snap_valid),
    .snap         (snap),
    .snap_ready   (snap_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .suspicious   (suspicious),
    .reason       (reason),
    .label_length (label_length)
  );

endmodule

// ===== sv/dlc_checker.sv =====
// Port-level checks for the domain label classifier, bound to the top level.
module dlc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            last,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            suspicious,
  input logic [2:0]                      reason,
  input logic [dlc_pkg::LABEL_W-1:0]     label_length
);
  import dlc_pkg::*;

  logic [2:0] pending;
  logic [2:0] pending_next;
  logic       last_in;
  logic       result_out;

  assign last_in    = in_valid && !in_stall && last;
  assign result_out = out_valid && !out_stall;

  always_comb begin
    pending_next = pending + 3'(last_in) - 3'(result_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  // Every result transaction must be owed to an accepted last item.
  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without a pending last item");

  // Input backpressure only comes from a full, stalled result side.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result side can move");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(reason) && $stable(suspicious)
                                  && $stable(label_length)))
    else $error("stalled result changed");

endmodule

bind dga_domain_label_classifier_core dlc_checker u_dlc_checker (.*);

// ===== test/tb_dga_domain_label_classifier_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the domain label classifier core.

import dlc_pkg::*;

class label_verdict_model;
  typedef struct {
    logic                 suspicious;
    reason_t              reason;
    logic [LABEL_W-1:0]   label_length;
  } verdict_t;

  verdict_t pending[$];
  int errors;
  int items_seen;
  int verdicts_checked;
  int reason_tally[5];

  logic [LONG_LIMIT_W-1:0]  long_limit;
  logic [ENT_LIMIT_W-1:0]   entropy_limit;
  logic [DIGIT_RATIO_W-1:0] digit_ratio;
  logic [MIN_LENGTH_W-1:0]  digit_min;
  logic [MIN_LENGTH_W-1:0]  vowel_min;

  bit     dot_seen;
  bit     vowel_found;
  int     length_count;
  int     digit_tally;
  int     bin_count[SYMBOL_BINS];
  longint flogf_sum;

  function new();
    long_limit    = 20;
    entropy_limit = 249037;
    digit_ratio   = 3;
    digit_min     = 5;
    vowel_min     = 8;
    clear_domain();
  endfunction

  function void clear_domain();
    dot_seen     = 1'b0;
    vowel_found  = 1'b0;
    length_count = 0;
    digit_tally  = 0;
    flogf_sum    = 0;
    foreach (bin_count[i]) begin
      bin_count[i] = 0;
    end
  endfunction

  // Base-two logarithm in unsigned Q16; the fraction comes from squaring a Q30 mantissa.
  function longint log_two_q16(int x);
    int whole;
    logic [63:0] m;
    logic [15:0] frac;
    whole = 0;
    frac = '0;
    if (x <= 0) begin
      return 0;
    end
    while ((x >> (whole + 1)) != 0) begin
      whole++;
    end
    m = 64'(x) << (30 - whole);
    repeat (16) begin
      m = (m * m) >> 30;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (longint'(whole) << 16) | longint'(frac);
  endfunction

  function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LONG_LIMIT:    long_limit    = data[LONG_LIMIT_W-1:0];
      CFG_ENTROPY_LIMIT: entropy_limit = data[ENT_LIMIT_W-1:0];
      CFG_DIGIT_RATIO:   digit_ratio   = data[DIGIT_RATIO_W-1:0];
      CFG_DIGIT_MIN:     digit_min     = data[MIN_LENGTH_W-1:0];
      CFG_VOWEL_MIN:     vowel_min     = data[MIN_LENGTH_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_item(logic [15:0] code, logic has, logic fin);
    int n;
    int old;
    logic [7:0] bin;
    logic [15:0] folded;
    longint scaled_entropy;
    longint scaled_limit;
    verdict_t v;
    items_seen++;
    if (has && !dot_seen) begin
      if (code == 16'(CHAR_DOT)) begin
        dot_seen = 1'b1;
      end else begin
        n = (length_count < MAX_LABEL) ? length_count : MAX_LABEL;
        if (length_count < LEN_SAT) begin
          length_count++;
        end
        if (n < MAX_LABEL) begin
          bin = (code > 16'(BIN_MAX)) ? CHAR_X : code[7:0];
          if (bin >= CHAR_UPPER_A && bin <= CHAR_UPPER_Z) begin
            bin = bin + CASE_OFFSET;
          end
          old = bin_count[bin];
          bin_count[bin] = old + 1;
          flogf_sum += longint'(old + 1) * log_two_q16(old + 1)
                       - longint'(old) * log_two_q16(old);
          if (code >= 16'(CHAR_ZERO) && code <= 16'(CHAR_NINE)) begin
            digit_tally++;
          end
          folded = code | 16'(CASE_OFFSET);
          if (folded == {8'h00, "a"} || folded == {8'h00, "e"} ||
              folded == {8'h00, "i"} || folded == {8'h00, "o"} ||
              folded == {8'h00, "u"}) begin
            vowel_found = 1'b1;
          end
        end
      end
    end
    if (fin) begin
      n = (length_count < MAX_LABEL) ? length_count : MAX_LABEL;
      scaled_entropy = longint'(n) * log_two_q16(n) - flogf_sum;
      scaled_limit = longint'(entropy_limit) * n;
      if (length_count > long_limit) begin
        v.reason = REASON_LONG;
      end else if (scaled_entropy > scaled_limit) begin
        v.reason = REASON_ENTROPY;
      end else if (length_count > digit_min &&
                   digit_tally * DIGIT_SCALE > n * digit_ratio) begin
        v.reason = REASON_DIGITS;
      end else if (length_count > vowel_min && !vowel_found) begin
        v.reason = REASON_NO_VOWEL;
      end else begin
        v.reason = REASON_NONE;
      end
      v.suspicious = (v.reason != REASON_NONE);
      v.label_length = LABEL_W'((length_count > LABEL_SAT) ? LABEL_SAT : length_count);
      pending.insert(pending.size(), v);
      clear_domain();
    end
  endfunction

  function void check_verdict(logic susp, logic [2:0] rsn, logic [LABEL_W-1:0] len);
    verdict_t v;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: result with no label pending: suspicious %0b reason %0d length %0d",
               $time, susp, rsn, len);
      return;
    end
    v = pending.pop_front();
    verdicts_checked++;
    reason_tally[v.reason]++;
    if (susp !== v.suspicious) begin
      errors++;
      $display("%0t: suspicious expected %0b got %0b", $time, v.suspicious, susp);
    end
    if (rsn !== v.reason) begin
      errors++;
      $display("%0t: reason expected %0d got %0d", $time, v.reason, rsn);
    end
    if (len !== v.label_length) begin
      errors++;
      $display("%0t: label_length expected %0d got %0d", $time, v.label_length, len);
    end
  endfunction
endclass

module tb_dga_domain_label_classifier_core;
  localparam int NO_PROGRESS_LIMIT = 4000;
  localparam int DRAIN_CYCLES      = 12;
  localparam int RANDOM_ITEMS      = 900;
  localparam int PHASES            = 7;
  localparam int IDLE_PERCENT      = 38;
  localparam string ALNUM          =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string CONSONANT_SET  = "bcdfghjklmnpqrstvwxyzBCDFG";

  typedef enum int {
    LOWER_ALPHA, MIXED_ALNUM, CONSONANTS, DIGIT_HEAVY, WIDE_NOISE, FEW_SYMBOLS
  } char_style_t;

  typedef enum int {END_ON_CHAR, END_MARKER, END_AFTER_DOT} domain_end_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [15:0]            char_code;
  logic                   has_char;
  logic                   last;
  logic                   out_valid;
  logic                   out_stall;
  logic                   suspicious;
  logic [2:0]             reason;
  logic [LABEL_W-1:0]     label_length;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  label_verdict_model verdicts;
  int idle_cycles = 0;
  int items_sent = 0;
  int settings_used = 0;
  bit gaps_on = 1'b1;

  dga_domain_label_classifier_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .has_char     (has_char),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .suspicious   (suspicious),
    .reason       (reason),
    .label_length (label_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        verdicts.take_item(char_code, has_char, last);
      end
      if (out_valid && !out_stall) begin
        verdicts.check_verdict(suspicious, reason, label_length);
      end
      if (cfg_valid && cfg_ready) begin
        verdicts.write_reg(cfg_index, cfg_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= NO_PROGRESS_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, NO_PROGRESS_LIMIT);
    $display("tb_dga_domain_label_classifier_core: done, errors");
    $finish;
  end

  task automatic send_item(logic [15:0] code, logic has, logic fin);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= code;
    has_char  <= has;
    last      <= fin;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item({8'h00, s[i]}, 1'b1, i == s.len() - 1);
    end
  endtask

  function automatic logic [15:0] pick_char(char_style_t style);
    case (style)
      LOWER_ALPHA: return {8'h00, "a"} + 16'($urandom_range(0, 25));
      MIXED_ALNUM: return {8'h00, ALNUM[$urandom_range(0, ALNUM.len() - 1)]};
      CONSONANTS:  return {8'h00, CONSONANT_SET[$urandom_range(0, CONSONANT_SET.len() - 1)]};
      DIGIT_HEAVY: begin
        if ($urandom_range(0, 9) < 7) begin
          return {8'h00, "0"} + 16'($urandom_range(0, 9));
        end
        return {8'h00, "a"} + 16'($urandom_range(0, 25));
      end
      WIDE_NOISE: begin
        if ($urandom_range(0, 1) == 0) begin
          return 16'($urandom_range(0, 255));
        end
        return 16'($urandom);
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          return 16'($urandom_range(256, 65535));
        end
        return {8'h00, "a"} + 16'($urandom_range(0, 2));
      end
    endcase
  endfunction

  task automatic send_domain();
    int pick;
    int label_len;
    int suffix_len;
    char_style_t style;
    domain_end_t ending;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      label_len = $urandom_range(0, 16);
    end else if (pick < 92) begin
      label_len = $urandom_range(17, 30);
    end else begin
      label_len = $urandom_range(55, 80);
    end
    style = char_style_t'($urandom_range(0, 5));
    ending = domain_end_t'($urandom_range(0, 2));
    if (ending == END_ON_CHAR && label_len == 0) begin
      ending = END_MARKER;
    end
    for (int i = 0; i < label_len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(16'($urandom), 1'b0, 1'b0);
      end
      send_item(pick_char(style), 1'b1, ending == END_ON_CHAR && i == label_len - 1);
    end
    if (ending == END_MARKER) begin
      send_item(16'($urandom), 1'b0, 1'b1);
    end else if (ending == END_AFTER_DOT) begin
      suffix_len = $urandom_range(0, 6);
      send_item(16'(CHAR_DOT), 1'b1, suffix_len == 0);
      for (int i = 0; i < suffix_len; i++) begin
        send_item(pick_char(char_style_t'($urandom_range(0, 5))),
                  $urandom_range(0, 7) != 0, i == suffix_len - 1);
      end
    end
  endtask

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] with_junk(int value, int width, bit junk);
    logic [CFG_DATA_W-1:0] upper;
    upper = junk ? (CFG_DATA_W'($urandom) << width) : '0;
    return CFG_DATA_W'(value) | upper;
  endfunction

  task automatic apply_setting(int ll, int el, int dr, int dm, int vm, bit junk);
    write_cfg(CFG_LONG_LIMIT, with_junk(ll, LONG_LIMIT_W, junk));
    write_cfg(CFG_ENTROPY_LIMIT, with_junk(el, ENT_LIMIT_W, junk));
    write_cfg(CFG_DIGIT_RATIO, with_junk(dr, DIGIT_RATIO_W, junk));
    write_cfg(CFG_DIGIT_MIN, with_junk(dm, MIN_LENGTH_W, junk));
    write_cfg(CFG_VOWEL_MIN, with_junk(vm, MIN_LENGTH_W, junk));
    if (junk) begin
      write_cfg(CFG_INDEX_W'(CFG_VOWEL_MIN) + CFG_INDEX_W'($urandom_range(1, 3)),
                CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (verdicts.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic run_phase(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      send_domain();
    end
    settle();
  endtask

  initial begin
    verdicts = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    char_code = '0;
    has_char  = 1'b0;
    last      = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) begin
      @(negedge clk);
    end
    rst <= 1'b0;
    apply_setting(20, 249037, 3, 5, 8, 1'b1);

    // Empty domain, case folding and a dot, wide and zero codes, then threshold cases.
    send_item(16'h0000, 1'b0, 1'b1);
    send_text("Ab9.zz");
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0100, 1'b1, 1'b0);
    send_item(16'hA5A5, 1'b0, 1'b0);
    send_item({8'h00, "X"}, 1'b1, 1'b1);
    send_item(16'(CHAR_DOT), 1'b1, 1'b1);
    send_text("qwrtzpsdf");
    send_text("12345a7");
    settle();

    run_phase(RANDOM_ITEMS / PHASES);
    apply_setting(0, 0, 0, 0, 0, 1'b0);
    run_phase(RANDOM_ITEMS / PHASES);
    apply_setting(63, (1 << ENT_LIMIT_W) - 1, 15, 63, 63, 1'b0);
    run_phase(RANDOM_ITEMS / PHASES);
    apply_setting(62, 524288, 10, 0, 0, 1'b1);
    run_phase(RANDOM_ITEMS / PHASES);
    gaps_on = 1'b0;
    apply_setting($urandom_range(0, 63), $urandom_range(150000, 300000),
                  $urandom_range(0, 15), $urandom_range(0, 20), $urandom_range(0, 20), 1'b1);
    run_phase(RANDOM_ITEMS / PHASES);
    gaps_on = 1'b1;
    apply_setting($urandom_range(0, 63), $urandom_range(0, (1 << ENT_LIMIT_W) - 1),
                  $urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 63), 1'b1);
    run_phase(RANDOM_ITEMS / PHASES);
    apply_setting(20, 249037, 3, 5, 8, 1'b0);
    run_phase(RANDOM_ITEMS / PHASES);

    $display("checked %0d verdicts from %0d accepted items under %0d register settings",
             verdicts.verdicts_checked, verdicts.items_seen, settings_used);
    $display("verdicts by reason: none %0d, long %0d, entropy %0d, digits %0d, no vowel %0d",
             verdicts.reason_tally[REASON_NONE], verdicts.reason_tally[REASON_LONG],
             verdicts.reason_tally[REASON_ENTROPY], verdicts.reason_tally[REASON_DIGITS],
             verdicts.reason_tally[REASON_NO_VOWEL]);
    if (verdicts.errors == 0) begin
      $display("tb_dga_domain_label_classifier_core: done, clean");
    end else begin
      $display("tb_dga_domain_label_classifier_core: done, errors");
    end
    $finish;
  end
endmodule
